// ----- rtl/ovl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ovl_pkg
// Shared types and codes for the ordered value list.
// ----------------------------------------------------------------------------
package ovl_pkg;

   localparam int unsigned CAPACITY_DEF = 64;

   localparam int unsigned OP_W    = 2;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned STAT_W  = 2;
   localparam int unsigned POS_W   = 6;
   localparam int unsigned CNT_W   = 7;

   typedef logic [OP_W-1:0]           op_type;
   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [STAT_W-1:0]         stat_type;
   typedef logic [POS_W-1:0]          pos_type;
   typedef logic [CNT_W-1:0]          cnt_type;

   localparam op_type OP_INSERT = 2'd0;
   localparam op_type OP_REMOVE = 2'd1;
   localparam op_type OP_SEARCH = 2'd2;

   localparam stat_type ST_DONE    = 2'd0;
   localparam stat_type ST_MISSING = 2'd1;
   localparam stat_type ST_FULL    = 2'd2;

endpackage : ovl_pkg
`default_nettype wire

// ----- rtl/ordered_value_list.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_value_list
// Bounded ordered store of signed 32-bit values with insert, remove and
// search, built around one memory port and one shared equality compare.
// ----------------------------------------------------------------------------
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------
//   req      | req_valid/req_stall  | req_operation, req_value
//   rsp      | rsp_valid/rsp_stall  | rsp_status, rsp_position, rsp_entry_count
//
// Steps: insert, an unused code, and remove or search on an empty list go
// from IDLE to FINISH. Remove and search visit READ and CMP per entry scanned
// from the head (one registered memory read, one compare); a remove then
// visits SH_RD, SH_WR per entry moved headward. One memory port sets this.
// Reset clears the entry count and the control; stored values need no clear.
// A pending response may sit in its output register while the next request
// is taken; the sequencer only waits in FINISH if that register is full and stalled.
// ----------------------------------------------------------------------------
module ordered_value_list #(
   parameter int unsigned CAPACITY = ovl_pkg::CAPACITY_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,

   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire ovl_pkg::op_type    req_operation,
   input  wire ovl_pkg::value_type req_value,

   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      ovl_pkg::stat_type  rsp_status,
   output      ovl_pkg::pos_type   rsp_position,
   output      ovl_pkg::cnt_type   rsp_entry_count
);
   import ovl_pkg::*;

   localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
   localparam logic [CW-1:0] CNT_ONE = CW'(1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_CMP,
      S_SH_RD,
      S_SH_WR,
      S_FINISH
   } state_type;

   state_type       state_ff;
   op_type          op_ff;
   value_type       key_ff;
   logic [CW-1:0]   count_ff;
   logic [CW-1:0]   idx_ff;
   stat_type        stat_ff;
   logic [CW-1:0]   pos_ff;

   logic            rsp_valid_ff;
   stat_type        rsp_status_ff;
   pos_type         rsp_position_ff;
   cnt_type         rsp_count_ff;

   // entry store: one write, one registered read per cycle
   value_type       mem [CAPACITY];
   value_type       rd_data_ff;
   logic            mem_we;
   logic [IW-1:0]   mem_wa;
   value_type       mem_wd;
   logic [IW-1:0]   mem_ra;

   logic            req_fire;
   logic            out_free;
   logic [CW-1:0]   idx_nx;
   logic [CW:0]     idx_nx2;
   logic            hit;
   logic [31:0]     pos_wide;
   logic [31:0]     cnt_wide;

   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign idx_nx    = idx_ff + CNT_ONE;
   assign idx_nx2   = {1'b0, idx_nx} + {1'b0, CNT_ONE};
   assign hit       = (rd_data_ff == key_ff);
   assign pos_wide  = 32'(pos_ff);
   assign cnt_wide  = 32'(count_ff);

   // memory port steering
   always_comb begin
      mem_we = 1'b0;
      mem_wa = count_ff[IW-1:0];
      mem_wd = req_value;
      mem_ra = idx_ff[IW-1:0];
      unique case (state_ff)
         S_IDLE: begin
            // append at tail while taking an insert
            mem_we = req_fire && (req_operation == OP_INSERT) && (count_ff != CAP_C);
         end
         S_SH_RD: begin
            mem_ra = idx_nx[IW-1:0];
         end
         S_SH_WR: begin
            mem_we = 1'b1;
            mem_wa = idx_ff[IW-1:0];
            mem_wd = rd_data_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[mem_ra];
   end

   // sequencer with registered response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop the response once taken, unless FINISH replaces it
         if (rsp_valid_ff && !rsp_stall && state_ff != S_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  op_ff  <= req_operation;
                  key_ff <= req_value;
                  idx_ff <= '0;
                  pos_ff <= '0;
                  if (req_operation == OP_INSERT) begin
                     state_ff <= S_FINISH;
                     if (count_ff == CAP_C) begin
                        stat_ff <= ST_FULL;
                     end else begin
                        stat_ff  <= ST_DONE;
                        count_ff <= count_ff + CNT_ONE;
                     end
                  end else if ((req_operation == OP_REMOVE ||
                                req_operation == OP_SEARCH) && count_ff != '0) begin
                     stat_ff  <= ST_MISSING;
                     state_ff <= S_READ;
                  end else begin
                     stat_ff  <= ST_MISSING;
                     state_ff <= S_FINISH;
                  end
               end
            end

            S_READ: begin
               state_ff <= S_CMP;
            end

            S_CMP: begin
               if (hit) begin
                  pos_ff  <= idx_ff;
                  stat_ff <= ST_DONE;
                  if (op_ff == OP_REMOVE) begin
                     if (idx_nx < count_ff) begin
                        state_ff <= S_SH_RD;
                     end else begin
                        count_ff <= count_ff - CNT_ONE;
                        state_ff <= S_FINISH;
                     end
                  end else begin
                     state_ff <= S_FINISH;
                  end
               end else begin
                  idx_ff <= idx_nx;
                  if (idx_nx == count_ff) begin
                     state_ff <= S_FINISH;
                  end else begin
                     state_ff <= S_READ;
                  end
               end
            end

            S_SH_RD: begin
               state_ff <= S_SH_WR;
            end

            S_SH_WR: begin
               // move entry idx+1 into idx, then advance
               idx_ff <= idx_nx;
               if (idx_nx2 < {1'b0, count_ff}) begin
                  state_ff <= S_SH_RD;
               end else begin
                  count_ff <= count_ff - CNT_ONE;
                  state_ff <= S_FINISH;
               end
            end

            S_FINISH: begin
               // hold until the output register is free
               if (out_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_status_ff   <= stat_ff;
                  rsp_position_ff <= pos_wide[POS_W-1:0];
                  rsp_count_ff    <= cnt_wide[CNT_W-1:0];
                  state_ff        <= S_IDLE;
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_position    = rsp_position_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule : ordered_value_list
`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ordered value list. A shadow queue tracks the
// stored values and yields the expected status, position and entry count of
// every request. Directed tests cover the empty list, the signed value
// extremes, duplicates, the unused operation code and a full list. Random
// traffic then follows a wandering fill target under four idling patterns.
// ----------------------------------------------------------------------------
module tb;
   import ovl_pkg::*;

   localparam int unsigned CAPACITY       = CAPACITY_DEF;
   // Worst single request: scan and shift across a full list, plus slack.
   localparam int          DRAIN_CYCLES   = 4 * CAPACITY + 32;
   localparam int          WATCHDOG_LIMIT = 20000;

   // The fourth operation code has no meaning in the block.
   localparam op_type    OP_UNUSED = 2'd3;
   localparam value_type VAL_MIN   = value_type'(32'h8000_0000);
   localparam value_type VAL_MAX   = value_type'(32'h7fff_ffff);

   typedef struct packed {
      stat_type status;
      pos_type  position;
      cnt_type  entry_count;
   } outcome_type;

   logic      clock = 1'b0;
   logic      reset;
   logic      req_valid;
   logic      req_stall;
   op_type    req_operation;
   value_type req_value;
   logic      rsp_valid;
   logic      rsp_stall;
   stat_type  rsp_status;
   pos_type   rsp_position;
   cnt_type   rsp_entry_count;

   // Shadow of the stored values, head first, and the outcomes still owed.
   value_type   shadow_list[$];
   outcome_type pending_outcomes[$];

   int send_idle_pct;
   int stall_pct;
   int error_count = 0;
   int idle_cycles = 0;

   always #1 clock = ~clock;

   ordered_value_list #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_position   (rsp_position),
      .rsp_entry_count(rsp_entry_count)
   );

   // Apply one request to the shadow list and return what the block must report.
   function automatic outcome_type list_outcome(input op_type op, input value_type val);
      outcome_type res;
      int          hit;
      res.status   = ST_MISSING;
      res.position = '0;
      hit          = -1;
      if (op == OP_REMOVE || op == OP_SEARCH) begin
         for (int i = 0; i < shadow_list.size() && hit < 0; i++) begin
            if (shadow_list[i] == val) hit = i;
         end
      end
      case (op)
         OP_INSERT: begin
            if (shadow_list.size() >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               shadow_list.push_back(val);
               res.status = ST_DONE;
            end
         end
         OP_REMOVE: begin
            if (hit >= 0) begin
               shadow_list.delete(hit);
               res.status   = ST_DONE;
               res.position = pos_type'(hit);
            end
         end
         OP_SEARCH: begin
            if (hit >= 0) begin
               res.status   = ST_DONE;
               res.position = pos_type'(hit);
            end
         end
         default: ;
      endcase
      res.entry_count = cnt_type'(shadow_list.size());
      return res;
   endfunction

   // Draw a value: mostly one already stored when a match is wanted, else a
   // small value that tends to repeat, an extreme, or any 32-bit pattern.
   function automatic value_type pick_value(input bit prefer_stored);
      int r;
      r = $urandom_range(99);
      if (prefer_stored && shadow_list.size() != 0 && r < 65)
         return shadow_list[$urandom_range(shadow_list.size() - 1)];
      if (r < 80) return value_type'(int'($urandom_range(8)) - 4);
      if (r < 84) return ($urandom_range(1) != 0) ? VAL_MIN : VAL_MAX;
      return value_type'($urandom);
   endfunction

   // Offer one request, hold it through any stall, and log its outcome once taken.
   task automatic send_request(input op_type op, input value_type val);
      while ($urandom_range(99) < send_idle_pct) begin
         // Drop valid and scramble the idle payload as noise.
         req_valid     <= 1'b0;
         req_operation <= op_type'($urandom);
         req_value     <= value_type'($urandom);
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_value     <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_outcomes.push_back(list_outcome(op, val));
   endtask

   task automatic report_mismatch(input string field, input int exp_v, input int act_v);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
      error_count++;
   endtask

   // Remove and search on an empty list find nothing.
   task automatic test_empty_list();
      send_request(OP_SEARCH, value_type'(5));
      send_request(OP_REMOVE, value_type'(5));
   endtask

   // Store both signed extremes, zero and all ones; search some by value and check the position.
   task automatic test_value_extremes();
      send_request(OP_INSERT, VAL_MIN);
      send_request(OP_INSERT, VAL_MAX);
      send_request(OP_INSERT, value_type'(0));
      send_request(OP_INSERT, value_type'(-1));
      send_request(OP_SEARCH, VAL_MAX);
      send_request(OP_SEARCH, value_type'(-1));
      send_request(OP_SEARCH, value_type'(1));
      send_request(OP_REMOVE, VAL_MIN);
      send_request(OP_SEARCH, VAL_MAX);
   endtask

   // The unused code changes nothing, on a list with entries.
   task automatic test_unused_code();
      send_request(OP_UNUSED, VAL_MAX);
      send_request(OP_SEARCH, VAL_MAX);
   endtask

   // Duplicates: remove and search must always hit the first copy; then drain.
   task automatic test_duplicates();
      send_request(OP_INSERT, value_type'(7));
      send_request(OP_INSERT, value_type'(7));
      send_request(OP_REMOVE, value_type'(7));
      send_request(OP_SEARCH, value_type'(7));
      send_request(OP_REMOVE, value_type'(7));
      send_request(OP_REMOVE, value_type'(7));
      send_request(OP_REMOVE, value_type'(0));
      send_request(OP_REMOVE, value_type'(-1));
      send_request(OP_REMOVE, VAL_MAX);
      send_request(OP_REMOVE, VAL_MAX);
   endtask

   // Fill to capacity, overflow, then scan the deepest entries.
   task automatic test_fill_to_capacity();
      while (shadow_list.size() < CAPACITY) send_request(OP_INSERT, value_type'($urandom));
      repeat (3) send_request(OP_INSERT, value_type'($urandom));
      send_request(OP_SEARCH, shadow_list[CAPACITY - 1]);
      send_request(OP_SEARCH, value_type'(int'($urandom_range(8)) - 4));
      send_request(OP_REMOVE, shadow_list[CAPACITY - 1]);
      send_request(OP_REMOVE, shadow_list[0]);
      send_request(OP_INSERT, VAL_MIN);
   endtask

   // Random traffic steered by a fill target that changes every 80 requests,
   // so the list keeps swinging between empty, mid-depth and full.
   task automatic test_random_traffic(input int n_items);
      int        target_fill;
      int        pick;
      op_type    op;
      value_type val;
      target_fill = $urandom_range(CAPACITY);
      for (int k = 0; k < n_items; k++) begin
         if (k % 80 == 0) begin
            case ($urandom_range(3))
               0:       target_fill = 0;
               1:       target_fill = CAPACITY + 4;
               default: target_fill = $urandom_range(CAPACITY - 1, 1);
            endcase
         end
         pick = $urandom_range(99);
         if (pick < 3)
            op = OP_UNUSED;
         else if (shadow_list.size() < target_fill)
            op = (pick < 65) ? OP_INSERT : (pick < 82) ? OP_REMOVE : OP_SEARCH;
         else
            op = (pick < 18) ? OP_INSERT : (pick < 62) ? OP_REMOVE : OP_SEARCH;
         val = pick_value(op != OP_INSERT);
         send_request(op, val);
      end
   endtask

   // Check each accepted response against the oldest outcome owed, then
   // decide the stall for the next cycle.
   always @(posedge clock) begin : check_responses
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: response with nothing outstanding, status %0d position %0d count %0d",
                     $time, rsp_status, rsp_position, rsp_entry_count);
            error_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", want.status, rsp_status);
            if (rsp_position !== want.position)
               report_mismatch("position", want.position, rsp_position);
            if (rsp_entry_count !== want.entry_count)
               report_mismatch("entry_count", want.entry_count, rsp_entry_count);
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // End the run if neither channel moves for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : run_tests
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_operation <= OP_INSERT;
      req_value     <= '0;
      send_idle_pct = 0;
      stall_pct     = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part, no idling.
      test_empty_list();
      test_value_extremes();
      test_unused_code();
      test_duplicates();
      test_fill_to_capacity();

      // Random part, one phase per idling pattern.
      test_random_traffic(400);
      send_idle_pct = 64;
      stall_pct     = 0;
      test_random_traffic(400);
      send_idle_pct = 0;
      stall_pct     = 64;
      test_random_traffic(400);
      send_idle_pct = 29;
      stall_pct     = 29;
      test_random_traffic(400);

      // Drop valid, drain outstanding responses, then watch for strays.
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule : tb

// ----- sim.f -----
rtl/ovl_pkg.sv
rtl/ordered_value_list.sv
bench/tb.sv
